@@ design/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// shared constants and types of the cubic bezier easing block
// ----------------------------------------------------------------------------
package cbe_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int NEWTON_STEPS_DEF  = 10;
	localparam int VAL_W             = 18;   // q2.16 value width
	localparam int CX_W              = 17;   // control x width
	localparam int MUL_A_W           = 24;
	localparam int MUL_B_W           = 20;
	localparam int MUL_P_W           = MUL_A_W + MUL_B_W;
	localparam int MUL_M_W           = MUL_P_W - FRAC_BITS;
	localparam int ACC_W             = 32;
	localparam int QUO_W             = 18;   // quotient bits kept before clamp
	localparam int CFG_IDX_W         = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 2'd3;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic             neg;
		logic [QUO_W-1:0] quo;
	} div_res_t;

endpackage

@@ design/cbe_in_if.sv @@
// ----------------------------------------------------------------------------
// cbe_in_if
// request channel carrying one time value
// ----------------------------------------------------------------------------
interface cbe_in_if;
	logic              valid;
	logic              ready;
	logic signed [17:0] time_in;
	modport source (output valid, output time_in, input ready);
	modport sink (input valid, input time_in, output ready);
endinterface

@@ design/cbe_out_if.sv @@
// ----------------------------------------------------------------------------
// cbe_out_if
// result channel carrying one eased value
// ----------------------------------------------------------------------------
interface cbe_out_if;
	logic              valid;
	logic              ready;
	logic signed [17:0] eased_value;
	modport source (output valid, output eased_value, input ready);
	modport sink (input valid, input eased_value, output ready);
endinterface

@@ design/cbe_fmul.sv @@
// ----------------------------------------------------------------------------
// cbe_fmul
// shared fixed point multiplier, product floored by the fraction shift
// ----------------------------------------------------------------------------
module cbe_fmul (
	input  logic signed [cbe_pkg::MUL_A_W-1:0] a,
	input  logic signed [cbe_pkg::MUL_B_W-1:0] b,
	output logic signed [cbe_pkg::MUL_M_W-1:0] m
);
	logic signed [cbe_pkg::MUL_P_W-1:0] prod;

	assign prod = a * b;
	// dropping low bits of two's complement floors toward minus infinity
	assign m = prod[cbe_pkg::MUL_P_W-1:cbe_pkg::FRAC_BITS];
endmodule

@@ design/cbe_div.sv @@
// ----------------------------------------------------------------------------
// cbe_div
// serial restoring divider for the newton step, one quotient bit a cycle
// ----------------------------------------------------------------------------
module cbe_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [cbe_pkg::ACC_W-1:0] num,
	input  logic signed [cbe_pkg::ACC_W-1:0] den,
	output cbe_pkg::div_res_t                res
);
	localparam int NM_W  = cbe_pkg::ACC_W + cbe_pkg::FRAC_BITS;
	localparam int DS_W  = cbe_pkg::ACC_W + cbe_pkg::QUO_W;
	localparam int CNT_W = $clog2(cbe_pkg::QUO_W);

	logic                      run_q;
	logic                      done_q;
	logic                      ovf_q;
	logic                      neg_q;
	logic [cbe_pkg::QUO_W-1:0] quo_q;
	logic [NM_W-1:0]           rem_q;
	logic [DS_W-1:0]           dsh_q;
	logic [CNT_W-1:0]          cnt_q;

	logic [cbe_pkg::ACC_W-1:0] num_mag;
	logic [cbe_pkg::ACC_W-1:0] den_mag;
	logic [NM_W-1:0]           nm;
	logic [DS_W-1:0]           dlim;
	logic                      fits;

	always_comb begin
		num_mag = num[cbe_pkg::ACC_W-1] ? cbe_pkg::ACC_W'(-num) : cbe_pkg::ACC_W'(num);
		den_mag = den[cbe_pkg::ACC_W-1] ? cbe_pkg::ACC_W'(-den) : cbe_pkg::ACC_W'(den);
		nm      = {num_mag, {cbe_pkg::FRAC_BITS{1'b0}}};
		dlim    = {den_mag, {cbe_pkg::QUO_W{1'b0}}};
		fits    = DS_W'(rem_q) >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= num[cbe_pkg::ACC_W-1] ^ den[cbe_pkg::ACC_W-1];
				quo_q <= '0;
				rem_q <= nm;
				dsh_q <= dlim >> 1;
				cnt_q <= CNT_W'(cbe_pkg::QUO_W - 1);
				// quotient beyond the kept bits always clamps the parameter
				if (DS_W'(nm) >= dlim) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q <= 1'b0;
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				if (fits) begin
					rem_q <= NM_W'(DS_W'(rem_q) - dsh_q);
				end
				quo_q <= {quo_q[cbe_pkg::QUO_W-2:0], fits};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.busy = run_q;
	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.neg  = neg_q;
	assign res.quo  = quo_q;
endmodule

@@ design/cubic_bezier_easing_top.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_easing_top
// cubic bezier easing curve, newton solve of x(u)=t then y(u), q2.16
// ----------------------------------------------------------------------------
//  channel   dir  payload              handshake
//  in_ch     in   time_in     s18      valid/ready
//  out_ch    out  eased_value s18      valid/ready
//  cfg       in   cfg_index, cfg_data  cfg_we, no wait
//
//  t at or below 0 or at or above 1: the solve is skipped and the result goes
//  from S_DONE into the output register; otherwise each newton step runs the
//  micro ops OP_VV through OP_CUBE on the single shared multiplier, then waits
//  in S_DIVW for the bit-serial divider; the final y evaluation runs them again
//  reset restores the default control points; no other state survives a request
//  in_ch.ready is low while a request is in work; a result waiting in the
//  output register does not block the next request
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top #(
	parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cbe_in_if.sink                            in_ch,
	cbe_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [cbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbe_pkg::VAL_W-1:0]         cfg_data
);
	localparam int ITER_W = $clog2(NEWTON_STEPS + 1);
	localparam int VW     = cbe_pkg::VAL_W;
	localparam int AW     = cbe_pkg::ACC_W;
	localparam int MW     = cbe_pkg::MUL_M_W;
	localparam logic signed [VW-1:0] ONE   = VW'(1 << cbe_pkg::FRAC_BITS);
	localparam logic signed [AW-1:0] O_MAX = AW'((1 << (VW - 1)) - 1);
	localparam logic signed [AW-1:0] O_MIN = -AW'(1 << (VW - 1));

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CALC = 2'd1;
	localparam logic [1:0] S_DIVW = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// multiplier micro ops
	localparam logic [3:0] OP_VV   = 4'd0;
	localparam logic [3:0] OP_UU   = 4'd1;
	localparam logic [3:0] OP_VU   = 4'd2;
	localparam logic [3:0] OP_D1   = 4'd3;
	localparam logic [3:0] OP_D2   = 4'd4;
	localparam logic [3:0] OP_D3   = 4'd5;
	localparam logic [3:0] OP_W1   = 4'd6;
	localparam logic [3:0] OP_C1   = 4'd7;
	localparam logic [3:0] OP_W2   = 4'd8;
	localparam logic [3:0] OP_C2   = 4'd9;
	localparam logic [3:0] OP_CUBE = 4'd10;

	// configuration registers
	logic [cbe_pkg::CX_W-1:0] ctrl1_x_q;
	logic signed [VW-1:0]     ctrl1_y_q;
	logic [cbe_pkg::CX_W-1:0] ctrl2_x_q;
	logic signed [VW-1:0]     ctrl2_y_q;

	logic [1:0]               state_q;
	logic [3:0]               op_q;
	logic                     final_q;
	logic [ITER_W-1:0]        iter_q;
	logic signed [VW-1:0]     t_q;
	logic signed [VW-1:0]     u_q;
	logic signed [cbe_pkg::MUL_A_W-1:0] vv_q;
	logic signed [cbe_pkg::MUL_A_W-1:0] uu_q;
	logic signed [cbe_pkg::MUL_A_W-1:0] vu_q;
	logic signed [cbe_pkg::MUL_A_W-1:0] w_q;
	logic signed [AW-1:0]     acc_q;
	logic signed [AW-1:0]     d_q;
	logic signed [VW-1:0]     res_q;
	logic                     out_valid_q;
	logic signed [VW-1:0]     out_data_q;

	logic signed [VW:0]       v;
	logic signed [VW-1:0]     x1;
	logic signed [VW-1:0]     x2;
	logic signed [VW-1:0]     c1;
	logic signed [VW-1:0]     c2;
	logic signed [cbe_pkg::MUL_A_W-1:0] mul_a;
	logic signed [cbe_pkg::MUL_B_W-1:0] mul_b;
	logic signed [MW-1:0]     mul_m;
	logic signed [AW-1:0]     m1;
	logic signed [AW-1:0]     m3;
	logic signed [AW-1:0]     acc_next;
	logic signed [AW-1:0]     diff;
	logic signed [VW-1:0]     res_sat;
	logic                     div_start;
	cbe_pkg::div_res_t        div_res;
	logic signed [VW+1:0]     step;
	logic signed [VW+2:0]     u_new;
	logic signed [VW-1:0]     u_clamp;
	logic                     out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl1_x_q <= 17'd16384;
			ctrl1_y_q <= 18'sd6554;
			ctrl2_x_q <= 17'd16384;
			ctrl2_y_q <= 18'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbe_pkg::REG_CTRL1_X: ctrl1_x_q <= cfg_data[cbe_pkg::CX_W-1:0];
				cbe_pkg::REG_CTRL1_Y: ctrl1_y_q <= cfg_data;
				cbe_pkg::REG_CTRL2_X: ctrl2_x_q <= cfg_data[cbe_pkg::CX_W-1:0];
				cbe_pkg::REG_CTRL2_Y: ctrl2_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		v  = (VW + 1)'(ONE) - (VW + 1)'(u_q);
		x1 = {1'b0, ctrl1_x_q};
		x2 = {1'b0, ctrl2_x_q};
		// slope always uses x; the curve uses y on the final pass
		c1 = final_q ? ctrl1_y_q : x1;
		c2 = final_q ? ctrl2_y_q : x2;
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_VV: begin
				mul_a = cbe_pkg::MUL_A_W'(v);
				mul_b = cbe_pkg::MUL_B_W'(v);
			end
			OP_UU: begin
				mul_a = cbe_pkg::MUL_A_W'(u_q);
				mul_b = cbe_pkg::MUL_B_W'(u_q);
			end
			OP_VU: begin
				mul_a = cbe_pkg::MUL_A_W'(v);
				mul_b = cbe_pkg::MUL_B_W'(u_q);
			end
			OP_D1: begin
				mul_a = vv_q;
				mul_b = cbe_pkg::MUL_B_W'(x1);
			end
			OP_D2: begin
				mul_a = vu_q;
				mul_b = cbe_pkg::MUL_B_W'(x2 - x1);
			end
			OP_D3: begin
				mul_a = uu_q;
				mul_b = cbe_pkg::MUL_B_W'(ONE - x2);
			end
			OP_W1: begin
				mul_a = vv_q;
				mul_b = cbe_pkg::MUL_B_W'(u_q);
			end
			OP_C1: begin
				mul_a = w_q;
				mul_b = cbe_pkg::MUL_B_W'(c1);
			end
			OP_W2: begin
				mul_a = uu_q;
				mul_b = cbe_pkg::MUL_B_W'(v);
			end
			OP_C2: begin
				mul_a = w_q;
				mul_b = cbe_pkg::MUL_B_W'(c2);
			end
			OP_CUBE: begin
				mul_a = uu_q;
				mul_b = cbe_pkg::MUL_B_W'(u_q);
			end
			default: ;
		endcase
	end

	cbe_fmul u_fmul (
		.a(mul_a),
		.b(mul_b),
		.m(mul_m)
	);

	// bernstein weights 3, 6, 3 and 3, 3, 1 applied as shifts and adds
	always_comb begin
		m1 = AW'(mul_m);
		m3 = m1 + (m1 <<< 1);
		unique case (op_q)
			OP_D1, OP_C1: acc_next = m3;
			OP_D2:        acc_next = acc_q + (m3 <<< 1);
			OP_D3, OP_C2: acc_next = acc_q + m3;
			OP_CUBE:      acc_next = acc_q + m1;
			default:      acc_next = acc_q;
		endcase
		diff = acc_next - AW'(t_q);
		if (acc_next > O_MAX) begin
			res_sat = VW'(O_MAX);
		end else if (acc_next < O_MIN) begin
			res_sat = VW'(O_MIN);
		end else begin
			res_sat = VW'(acc_next);
		end
	end

	assign div_start = (state_q == S_CALC) && (op_q == OP_CUBE) && !final_q && (d_q != '0);

	cbe_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(diff),
		.den(d_q),
		.res(div_res)
	);

	// parameter update with clamp to the q2.16 range
	always_comb begin
		step = div_res.neg ? -(VW + 2)'({2'b00, div_res.quo})
			: (VW + 2)'({2'b00, div_res.quo});
		u_new = (VW + 3)'(u_q) - (VW + 3)'(step);
		if (div_res.ovf) begin
			// huge positive step drives u to the floor, negative to the ceiling
			u_clamp = div_res.neg ? VW'(O_MAX) : VW'(O_MIN);
		end else if (u_new > (VW + 3)'(O_MAX)) begin
			u_clamp = VW'(O_MAX);
		end else if (u_new < (VW + 3)'(O_MIN)) begin
			u_clamp = VW'(O_MIN);
		end else begin
			u_clamp = VW'(u_new);
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_VV;
			final_q     <= 1'b0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						t_q     <= in_ch.time_in;
						u_q     <= in_ch.time_in;
						op_q    <= OP_VV;
						final_q <= 1'b0;
						iter_q  <= '0;
						// out of range times skip the solve
						if (in_ch.time_in <= 0) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else if (in_ch.time_in >= ONE) begin
							res_q   <= ONE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					acc_q <= acc_next;
					unique case (op_q)
						OP_VV: vv_q <= cbe_pkg::MUL_A_W'(mul_m);
						OP_UU: uu_q <= cbe_pkg::MUL_A_W'(mul_m);
						OP_VU: vu_q <= cbe_pkg::MUL_A_W'(mul_m);
						OP_D3: d_q  <= acc_next;
						OP_W1, OP_W2: w_q <= cbe_pkg::MUL_A_W'(mul_m);
						default: ;
					endcase
					if (op_q == OP_CUBE) begin
						op_q <= OP_VV;
						if (final_q) begin
							res_q   <= res_sat;
							state_q <= S_DONE;
						end else if (d_q == '0) begin
							// flat slope ends the solve early
							final_q <= 1'b1;
						end else begin
							state_q <= S_DIVW;
						end
					end else begin
						op_q <= op_q + 1'b1;
					end
				end
				S_DIVW: begin
					if (div_res.done) begin
						u_q     <= u_clamp;
						iter_q  <= iter_q + 1'b1;
						state_q <= S_CALC;
						if (iter_q == ITER_W'(NEWTON_STEPS - 1)) begin
							final_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_data_q <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.eased_value = out_data_q;

`ifndef SYNTH
	// no request is taken while the divider is still working
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_res.busy) else $error("request taken during divide");
	// divider results only arrive while the sequencer waits for them
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_DIVW)) else $error("stray divider result");
	// step count never passes the configured limit
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= ITER_W'(NEWTON_STEPS)) else $error("too many newton steps");
`endif
endmodule

@@ dv/tb_cubic_bezier_easing_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_easing_top
// self-checking bench for the cubic bezier easing block: an in-bench
// fixed-point newton solver predicts each eased value, which is compared with
// the block's result in request order over several control point settings
// ----------------------------------------------------------------------------

// predicted eased values, waiting in request order
class easing_scoreboard;
	longint x1, y1, x2, y2;
	logic signed [17:0] eased_q[$];
	int mismatches;
	int stray;

	function new();
		x1 = 16384; y1 = 6554; x2 = 16384; y2 = 65536;
		mismatches = 0;
		stray = 0;
	endfunction

	// product of two q.16 values, rounded toward minus infinity
	function longint qmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function longint bezier(longint u, longint c1, longint c2);
		longint v, vv, uu;
		v = 65536 - u;
		vv = qmul(v, v);
		uu = qmul(u, u);
		return 3 * qmul(qmul(vv, u), c1) + 3 * qmul(qmul(v, uu), c2) + qmul(uu, u);
	endfunction

	function longint bezier_slope(longint u, longint c1, longint c2);
		longint v, vv, uu;
		v = 65536 - u;
		vv = qmul(v, v);
		uu = qmul(u, u);
		return 3 * qmul(vv, c1) + 6 * qmul(qmul(v, u), c2 - c1) + 3 * qmul(uu, 65536 - c2);
	endfunction

	function logic signed [17:0] ease(logic signed [17:0] t_in);
		longint t, u, d, r;
		t = t_in;
		if (t <= 0) begin
			r = 0;
		end else if (t >= 65536) begin
			r = 65536;
		end else begin
			u = t;
			for (int i = 0; i < cbe_pkg::NEWTON_STEPS_DEF; i++) begin
				d = bezier_slope(u, x1, x2);
				if (d == 0) break;
				u = u - ((bezier(u, x1, x2) - t) * 65536) / d;
				if (u > 131071) u = 131071;
				if (u < -131072) u = -131072;
			end
			r = bezier(u, y1, y2);
		end
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[17:0];
	endfunction

	function void set_reg(logic [1:0] idx, logic [17:0] data);
		case (idx)
			cbe_pkg::REG_CTRL1_X: x1 = data[16:0];
			cbe_pkg::REG_CTRL1_Y: y1 = $signed(data);
			cbe_pkg::REG_CTRL2_X: x2 = data[16:0];
			cbe_pkg::REG_CTRL2_Y: y2 = $signed(data);
			default: ;
		endcase
	endfunction

	function void note_request(logic signed [17:0] t);
		eased_q.push_back(ease(t));
	endfunction

	function void check_result(logic signed [17:0] got);
		logic signed [17:0] want;
		if (eased_q.size() == 0) begin
			stray++;
			$display("unexpected result %0d", got);
			return;
		end
		want = eased_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("eased_value mismatch: expected %0d got %0d", want, got);
		end
	endfunction
endclass

module tb_cubic_bezier_easing_top;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;

	cbe_in_if in_ch ();
	cbe_out_if out_ch ();

	easing_scoreboard sb = new();

	// both sides idle at random unless a quiet stretch is running
	bit idling_on = 1'b1;
	int results_seen = 0;
	bit held_once = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.time_in = '0;
		out_ch.ready = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cubic_bezier_easing_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// result side: random back-pressure, one long hold-off to fill the block
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			sb.check_result(out_ch.eased_value);
			results_seen++;
		end
		if (!held_once && results_seen == 250) begin
			held_once = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(idling_on && $urandom_range(99) < 38);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [17:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// control points only change once the block has drained
	task automatic set_curve(input logic [17:0] c1x, input logic [17:0] c1y,
			input logic [17:0] c2x, input logic [17:0] c2y);
		while (sb.eased_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(cbe_pkg::REG_CTRL1_X, c1x);
		write_reg(cbe_pkg::REG_CTRL1_Y, c1y);
		write_reg(cbe_pkg::REG_CTRL2_X, c2x);
		write_reg(cbe_pkg::REG_CTRL2_Y, c2y);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_time(input logic signed [17:0] t);
		if (idling_on && $urandom_range(99) < 38) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.time_in <= t;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(t);
	endtask

	// mostly times strictly inside 0..1, the rest anywhere in range
	task automatic send_random(input int n);
		logic [17:0] t;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80)
				t = 18'($urandom_range(65535, 1));
			else
				t = 18'($urandom);
			send_time(t);
		end
		in_ch.valid <= 1'b0;
	endtask

	// clamp edges, tiny times where the slope can flatten, midpoint, near one
	task automatic send_directed();
		logic signed [17:0] pts[15] = '{-18'sd131072, -18'sd1, 18'sd0, 18'sd1, 18'sd2,
			18'sd100, 18'sd255, 18'sd16384, 18'sd32768, 18'sd49152, 18'sd65535,
			18'sd65536, 18'sd65537, 18'sd131071, 18'sd43690};
		foreach (pts[i]) send_time(pts[i]);
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults from reset first, untouched
		send_directed();
		send_random(80);

		// rewrite the reset values, then sweep the extremes
		set_curve(18'd16384, 18'd6554, 18'd16384, 18'd65536);
		send_random(60);
		// flat curve start: slope vanishes for tiny u
		set_curve(18'd0, 18'd0, 18'd0, 18'd65536);
		send_directed();
		send_random(80);
		set_curve(18'd65536, 18'h1ffff, 18'd65536, 18'h20000);
		send_directed();
		send_random(80);
		// control x beyond one, parameter may run away
		set_curve(18'h1ffff, 18'h20000, 18'h1ffff, 18'h1ffff);
		send_directed();
		send_random(80);
		set_curve(18'd0, 18'h1ffff, 18'd65536, 18'h20000);
		send_random(60);

		// quiet stretch: no idling on either side
		idling_on = 1'b0;
		set_curve(18'd27525, 18'd0, 18'd38011, 18'd65536);
		send_random(150);
		idling_on = 1'b1;

		for (int p = 0; p < 4; p++) begin
			set_curve(18'($urandom), 18'($urandom), 18'($urandom_range(65536)),
				18'($urandom));
			send_random(60);
		end

		while (sb.eased_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.mismatches == 0 && sb.stray == 0 && sb.eased_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
